[rtl/hrm_pkg.sv]
// Shared types, constants and the square root step of the rate mixer.
package hrm_pkg;

  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned SqrtStages = 16;

  localparam logic [25:0]        SpeedMax   = 26'd65536000;
  localparam logic signed [53:0] SpeedSqMax = 54'sd65536000000;

  typedef enum logic [2:0] {
    REG_THRUST_SCALE = 3'd0,
    REG_ROLL_RATE    = 3'd1,
    REG_ROLL_CROSS   = 3'd2,
    REG_PITCH_RATE   = 3'd3,
    REG_PITCH_CROSS  = 3'd4,
    REG_YAW_RATE     = 3'd5,
    REG_YAW_CROSS    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] target_rate_x;
    logic signed [31:0] target_rate_y;
    logic signed [31:0] target_rate_z;
    logic signed [31:0] measured_rate_x;
    logic signed [31:0] measured_rate_y;
    logic signed [31:0] measured_rate_z;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
  } cmd_t;

  typedef struct packed {
    logic [25:0] rotor_speed_1;
    logic [25:0] rotor_speed_2;
    logic [25:0] rotor_speed_3;
    logic [25:0] rotor_speed_4;
    logic [25:0] rotor_speed_5;
    logic [25:0] rotor_speed_6;
  } rotors_t;

  // Word handed from the front end to the datapath.
  typedef struct packed {
    logic signed [32:0] err_x;
    logic signed [32:0] err_y;
    logic signed [32:0] err_z;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] mz;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
  } work_t;

  typedef struct packed {
    logic [30:0]        thrust_scale;
    logic signed [31:0] roll_rate_gain;
    logic signed [31:0] roll_cross_gain;
    logic signed [31:0] pitch_rate_gain;
    logic signed [31:0] pitch_cross_gain;
    logic signed [31:0] yaw_rate_gain;
    logic signed [31:0] yaw_cross_gain;
  } gains_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
    logic [63:0] rest;
  } sq_state_t;

  // One digit of the restoring integer square root.
  function automatic sq_state_t isqrt_step(sq_state_t s);
    sq_state_t   r;
    logic [34:0] rem_n;
    logic [34:0] trial;
    rem_n = {s.rem[32:0], s.rest[63:62]};
    trial = {1'b0, s.root, 2'b01};
    if (rem_n >= trial) begin
      r.rem  = rem_n - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = rem_n;
      r.root = {s.root[30:0], 1'b0};
    end
    r.rest = {s.rest[61:0], 2'b00};
    return r;
  endfunction

endpackage

[rtl/hrm_fifo.sv]
// Small first-in first-out queue with a combinational read port.
module hrm_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter type         T     = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  T     wdata_i,
  output logic ready_o,
  input  logic rd_i,
  output T     rdata_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign empty_o = (cnt_q == '0);
  assign ready_o = (cnt_q != CntW'(DEPTH)) || rd_i;
  assign do_wr   = wr_i && ready_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_wr) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/hrm_front.sv]
// Front end: accepts command words and forms the rate errors.
module hrm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  input  hrm_pkg::cmd_t cmd_i,
  output logic          full,
  output logic          valid_o,
  output hrm_pkg::work_t work_o,
  input  logic          ready_i
);

  logic           valid_q;
  hrm_pkg::work_t work_q, work_d;

  assign full    = valid_q && !ready_i;
  assign valid_o = valid_q;
  assign work_o  = work_q;

  always_comb begin
    work_d.err_x = 33'(cmd_i.target_rate_x) - 33'(cmd_i.measured_rate_x);
    work_d.err_y = 33'(cmd_i.target_rate_y) - 33'(cmd_i.measured_rate_y);
    work_d.err_z = 33'(cmd_i.target_rate_z) - 33'(cmd_i.measured_rate_z);
    work_d.mx    = cmd_i.measured_rate_x;
    work_d.my    = cmd_i.measured_rate_y;
    work_d.mz    = cmd_i.measured_rate_z;
    work_d.ax    = cmd_i.accel_x;
    work_d.ay    = cmd_i.accel_y;
    work_d.az    = cmd_i.accel_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!full) begin
      valid_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !full) begin
      work_q <= work_d;
    end
  end

endmodule

[rtl/hrm_sqrt_pipe.sv]
// Pipelined 64-bit floor square root, two digits per stage, with side data.
module hrm_sqrt_pipe #(
  parameter int unsigned PW = 2
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [63:0]   op_i,
  input  logic [PW-1:0] side_i,
  output logic [31:0]   root_o,
  output logic [PW-1:0] side_o
);

  localparam int unsigned N = hrm_pkg::SqrtStages;

  hrm_pkg::sq_state_t st_q   [N];
  logic [PW-1:0]      side_q [N];
  hrm_pkg::sq_state_t seed;

  assign seed = '{rem: '0, root: '0, rest: op_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0]   <= hrm_pkg::isqrt_step(hrm_pkg::isqrt_step(seed));
      side_q[0] <= side_i;
      for (int k = 1; k < N; k++) begin
        st_q[k]   <= hrm_pkg::isqrt_step(hrm_pkg::isqrt_step(st_q[k-1]));
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign root_o = st_q[N-1].root;
  assign side_o = side_q[N-1];

endmodule

[rtl/hrm_back.sv]
// Back end: moment terms, thrust norm, mixing and rotor speed roots.
module hrm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hrm_pkg::gains_t gains_i,
  input  logic            valid_i,
  input  hrm_pkg::work_t  work_i,
  output logic            take_o,
  output logic            valid_o,
  output hrm_pkg::rotors_t rotors_o,
  input  logic            ready_i
);

  localparam int unsigned Lat = 5 + 2 * hrm_pkg::SqrtStages;

  logic           adv;
  logic [Lat-1:0] valid_q;

  assign adv     = !valid_q[Lat-1] || ready_i;
  assign take_o  = adv && valid_i;
  assign valid_o = valid_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[Lat-2:0], valid_i};
    end
  end

  // Stage 0: squares and gyroscopic products.
  logic [62:0]        sqx_q, sqy_q, sqz_q;
  logic signed [63:0] cpr_q, cpp_q, cpy_q;
  logic signed [32:0] ex_q, ey_q, ez_q;
  logic signed [63:0] sqx_w, sqy_w, sqz_w;

  assign sqx_w = work_i.ax * work_i.ax;
  assign sqy_w = work_i.ay * work_i.ay;
  assign sqz_w = work_i.az * work_i.az;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx_q <= sqx_w[62:0];
      sqy_q <= sqy_w[62:0];
      sqz_q <= sqz_w[62:0];
      cpr_q <= work_i.my * work_i.mz;
      cpp_q <= work_i.mz * work_i.mx;
      cpy_q <= work_i.mx * work_i.my;
      ex_q  <= work_i.err_x;
      ey_q  <= work_i.err_y;
      ez_q  <= work_i.err_z;
    end
  end

  // Stage 1: sum of squares, rate terms, saturated rate products.
  function automatic logic signed [31:0] sat_prod(logic signed [63:0] p);
    logic signed [47:0] v;
    v = p[63:16];
    if (!v[47] && (v[46:31] != '0)) begin
      return 32'sh7FFF_FFFF;
    end else if (v[47] && (v[46:31] != '1)) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  logic [63:0]        sumsq_q;
  logic signed [64:0] rr_w, rp_w, ry_w;
  logic signed [48:0] rr_q, rp_q, ry_q;
  logic signed [31:0] sr_q, sp_q, sy_q;

  assign rr_w = gains_i.roll_rate_gain * ex_q;
  assign rp_w = gains_i.pitch_rate_gain * ey_q;
  assign ry_w = gains_i.yaw_rate_gain * ez_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sumsq_q <= 64'(sqx_q) + 64'(sqy_q) + 64'(sqz_q);
      rr_q    <= rr_w[64:16];
      rp_q    <= rp_w[64:16];
      ry_q    <= ry_w[64:16];
      sr_q    <= sat_prod(cpr_q);
      sp_q    <= sat_prod(cpp_q);
      sy_q    <= sat_prod(cpy_q);
    end
  end

  // Stage 2: cross terms.
  logic [63:0]        sumsq2_q;
  logic signed [48:0] rr2_q, rp2_q, ry2_q;
  logic signed [63:0] cr_q, cp_q, cy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sumsq2_q <= sumsq_q;
      rr2_q    <= rr_q;
      rp2_q    <= rp_q;
      ry2_q    <= ry_q;
      cr_q     <= gains_i.roll_cross_gain * sr_q;
      cp_q     <= gains_i.pitch_cross_gain * sp_q;
      cy_q     <= gains_i.yaw_cross_gain * sy_q;
    end
  end

  // Axis terms ride alongside the norm square root.
  logic signed [49:0] r_w, p_w, y_w;
  logic [149:0]       axes_side;
  logic [31:0]        norm;

  assign r_w = 50'(rr2_q) + 50'($signed(cr_q[63:16]));
  assign p_w = 50'(rp2_q) + 50'($signed(cp_q[63:16]));
  assign y_w = 50'(ry2_q) + 50'($signed(cy_q[63:16]));

  hrm_sqrt_pipe #(.PW(150)) u_norm (
    .clk_i  (clk_i),
    .en_i   (adv),
    .op_i   (sumsq2_q),
    .side_i ({r_w, p_w, y_w}),
    .root_o (norm),
    .side_o (axes_side)
  );

  // Thrust term.
  logic [62:0]        tprod_w;
  logic [46:0]        t_q;
  logic signed [49:0] r_q, p_q, y_q;

  assign tprod_w = 63'(gains_i.thrust_scale) * 63'(norm);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q <= tprod_w[62:16];
      r_q <= axes_side[149:100];
      p_q <= axes_side[99:50];
      y_q <= axes_side[49:0];
    end
  end

  // Mixing and range classification.
  logic signed [53:0] t_s, r_s, p_s, y_s;
  logic signed [53:0] sq_w [6];
  logic [63:0]        op_q [6];
  logic [1:0]         cls_q [6];

  assign t_s = 54'(t_q);
  assign r_s = 54'(r_q);
  assign p_s = 54'(p_q);
  assign y_s = 54'(y_q);

  always_comb begin
    sq_w[0] = t_s + r_s - p_s - y_s;
    sq_w[1] = t_s + (r_s <<< 1) + y_s;
    sq_w[2] = t_s + r_s + p_s - y_s;
    sq_w[3] = t_s - r_s + p_s + y_s;
    sq_w[4] = t_s - (r_s <<< 1) - y_s;
    sq_w[5] = t_s - r_s - p_s + y_s;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        op_q[i]  <= {12'd0, sq_w[i][35:0], 16'd0};
        cls_q[i] <= {(sq_w[i] <= 54'sd0), (sq_w[i] >= hrm_pkg::SpeedSqMax)};
      end
    end
  end

  logic [31:0] root [6];
  logic [1:0]  cls  [6];
  logic [25:0] spd  [6];

  for (genvar g = 0; g < 6; g++) begin : g_rotor
    hrm_sqrt_pipe #(.PW(2)) u_speed (
      .clk_i  (clk_i),
      .en_i   (adv),
      .op_i   (op_q[g]),
      .side_i (cls_q[g]),
      .root_o (root[g]),
      .side_o (cls[g])
    );
    assign spd[g] = cls[g][1] ? 26'd0 :
                    cls[g][0] ? hrm_pkg::SpeedMax : root[g][25:0];
  end

  assign rotors_o = '{rotor_speed_1: spd[0], rotor_speed_2: spd[1],
                      rotor_speed_3: spd[2], rotor_speed_4: spd[3],
                      rotor_speed_5: spd[4], rotor_speed_6: spd[5]};

endmodule

[rtl/hexarotor_rate_control_mixer.sv]
// Top level of the hexarotor body-rate controller and motor mixer.
//
// Usage: command words enter through a queue-style port. A word is taken at
// a rising clock edge where push is high and full is low. Results leave the
// same way: while empty is low the oldest rotor speed word is on result_o,
// and it is removed at an edge where pop is high.
// The seven gain registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i; writes to index seven are dropped, and only the low 31 bits
// of the thrust scale are kept. Write them while the block is idle.
// A word passes from push to result_o through the input register, the
// two-entry hand-off queue, the datapath (three multiply stages, the
// 16-stage norm square root, the thrust multiply, the mixer and the
// 16-stage rotor square roots) and the output queue. Throughput is one
// word per cycle while the receiver keeps popping; each square root unit
// resolves two result bits per stage.
// Reset clears the gain registers to zero and empties every queue and
// pipeline. When the receiver stops popping, the output queue fills, the
// datapath holds its contents, the hand-off queue fills and full rises; no
// word is lost and accepting resumes in the cycle pop returns.
module hexarotor_rate_control_mixer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  input  hrm_pkg::cmd_t                 cmd_i,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output hrm_pkg::rotors_t              result_o,
  input  logic                          cfg_we_i,
  input  logic [hrm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [31:0]                   cfg_data_i
);

  // Gain registers.
  hrm_pkg::gains_t gains_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= '0;
    end else if (cfg_we_i) begin
      unique case (hrm_pkg::reg_idx_e'(cfg_idx_i))
        hrm_pkg::REG_THRUST_SCALE: gains_q.thrust_scale     <= cfg_data_i[30:0];
        hrm_pkg::REG_ROLL_RATE:    gains_q.roll_rate_gain   <= cfg_data_i;
        hrm_pkg::REG_ROLL_CROSS:   gains_q.roll_cross_gain  <= cfg_data_i;
        hrm_pkg::REG_PITCH_RATE:   gains_q.pitch_rate_gain  <= cfg_data_i;
        hrm_pkg::REG_PITCH_CROSS:  gains_q.pitch_cross_gain <= cfg_data_i;
        hrm_pkg::REG_YAW_RATE:     gains_q.yaw_rate_gain    <= cfg_data_i;
        hrm_pkg::REG_YAW_CROSS:    gains_q.yaw_cross_gain   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end forms the rate errors and hands words to the queue.
  logic           front_valid, mid_ready;
  hrm_pkg::work_t front_work;

  hrm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .cmd_i   (cmd_i),
    .full    (full),
    .valid_o (front_valid),
    .work_o  (front_work),
    .ready_i (mid_ready)
  );

  // Hand-off queue lets the front end keep taking words while the datapath
  // is held by a stalled receiver.
  logic           mid_empty, back_take;
  hrm_pkg::work_t mid_work;

  hrm_fifo #(.DEPTH(2), .T(hrm_pkg::work_t)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (front_valid),
    .wdata_i (front_work),
    .ready_o (mid_ready),
    .rd_i    (back_take),
    .rdata_o (mid_work),
    .empty_o (mid_empty)
  );

  logic             back_valid, out_ready;
  hrm_pkg::rotors_t back_rotors;

  hrm_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .gains_i  (gains_q),
    .valid_i  (!mid_empty),
    .work_i   (mid_work),
    .take_o   (back_take),
    .valid_o  (back_valid),
    .rotors_o (back_rotors),
    .ready_i  (out_ready)
  );

  // Output queue decouples the datapath from the receiver.
  hrm_fifo #(.DEPTH(2), .T(hrm_pkg::rotors_t)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (back_valid),
    .wdata_i (back_rotors),
    .ready_o (out_ready),
    .rd_i    (pop),
    .rdata_o (result_o),
    .empty_o (empty)
  );

endmodule
